[rtl/cfglex_pkg.sv]
// shared types, character constants and helpers of the configuration text lexer
package cfglex_pkg;

   localparam int POS_W   = 16;
   localparam int LIMIT_W = 11;
   localparam int KIND_W  = 3;
   localparam int DATA_W  = 40;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1024;

   localparam logic [7:0] CHAR_UNDERSCORE = 8'h5f;
   localparam logic [7:0] CHAR_QUOTE      = 8'h22;
   localparam logic [7:0] CHAR_SLASH      = 8'h2f;
   localparam logic [7:0] CHAR_NEWLINE    = 8'h0a;
   localparam logic [7:0] CHAR_LBRACE     = 8'h7b;
   localparam logic [7:0] CHAR_RBRACE     = 8'h7d;
   localparam logic [7:0] CHAR_COLON      = 8'h3a;
   localparam logic [7:0] CHAR_COMMA      = 8'h2c;
   localparam logic [7:0] CHAR_POINT      = 8'h2e;
   localparam logic [7:0] CHAR_PLUS       = 8'h2b;
   localparam logic [7:0] CHAR_MINUS      = 8'h2d;
   localparam logic [7:0] CHAR_LOWER_E    = 8'h65;
   localparam logic [7:0] CHAR_UPPER_E    = 8'h45;

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_NAME,
      MODE_STR,
      MODE_NUM,
      MODE_SLASH,
      MODE_COMMENT
   } mode_type;

   typedef enum logic [2:0] {
      PHASE_INT,
      PHASE_FRAC,
      PHASE_EMARK,
      PHASE_ESIGN,
      PHASE_EDIG
   } phase_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_LBRACE,
      KIND_RBRACE,
      KIND_COLON,
      KIND_COMMA,
      KIND_NAME,
      KIND_STRING,
      KIND_NUMBER
   } kind_type;

   typedef struct packed {
      logic               last;
      kind_type           kind;
      logic [POS_W-1:0]   start;
      logic [POS_W-1:0]   length;
   } tok_type;

   // tokens produced by one accepted item, first one in slot 0
   typedef struct packed {
      logic    v0;
      logic    v1;
      tok_type t0;
      tok_type t1;
   } push_type;

   function automatic logic is_digit(input logic [7:0] c);
      return c inside {[8'h30:8'h39]};
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return (c inside {[8'h61:8'h7a]}) || (c inside {[8'h41:8'h5a]}) ||
             (c == CHAR_UNDERSCORE);
   endfunction

endpackage

[rtl/cfglex_core.sv]
// lexer state machine: one character per accepted item, up to two tokens out
module cfglex_core import cfglex_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         text_char,
   input  logic               end_of_text,
   input  logic [LIMIT_W-1:0] token_limit,
   output push_type           push
);

   mode_type           mode_ff, mode_in;
   phase_type          phase_ff, phase_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [POS_W-1:0]   start_ff, start_in;
   logic [LIMIT_W-1:0] count_ff, count_in;

   logic               e1_v, e2_v, relex, takes, k1, k2;
   kind_type           e1_kind, e2_kind;
   logic [POS_W-1:0]   span;
   logic [LIMIT_W-1:0] count_mid;
   tok_type            tok1, tok2;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         phase_ff <= PHASE_INT;
         pos_ff   <= '0;
         start_ff <= '0;
         count_ff <= '0;
      end else if (accept) begin
         mode_ff  <= mode_in;
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         start_ff <= start_in;
         count_ff <= count_in;
      end
   end

   always_comb begin
      mode_in  = mode_ff;
      phase_in = phase_ff;
      start_in = start_ff;
      pos_in   = pos_ff + POS_W'(1);
      e1_v     = 1'b0;
      e1_kind  = KIND_NAME;
      e2_v     = 1'b0;
      e2_kind  = KIND_LBRACE;
      relex    = 1'b0;
      takes    = 1'b0;
      span     = pos_ff - start_ff;

      // number continuation
      case (phase_ff)
         PHASE_INT: begin
            if (is_digit(text_char)) begin
               takes = 1'b1;
            end else if (text_char == CHAR_POINT) begin
               takes = 1'b1;  phase_in = PHASE_FRAC;
            end else if (text_char == CHAR_LOWER_E || text_char == CHAR_UPPER_E) begin
               takes = 1'b1;  phase_in = PHASE_EMARK;
            end
         end
         PHASE_FRAC: begin
            if (is_digit(text_char)) begin
               takes = 1'b1;
            end else if (text_char == CHAR_LOWER_E || text_char == CHAR_UPPER_E) begin
               takes = 1'b1;  phase_in = PHASE_EMARK;
            end
         end
         PHASE_EMARK: begin
            if (text_char == CHAR_PLUS || text_char == CHAR_MINUS) begin
               takes = 1'b1;  phase_in = PHASE_ESIGN;
            end else if (is_digit(text_char)) begin
               takes = 1'b1;  phase_in = PHASE_EDIG;
            end
         end
         PHASE_ESIGN: begin
            if (is_digit(text_char)) begin
               takes = 1'b1;  phase_in = PHASE_EDIG;
            end
         end
         PHASE_EDIG: begin
            takes = is_digit(text_char);
         end
         default: begin
            takes = 1'b0;
         end
      endcase
      if (mode_ff != MODE_NUM) begin
         phase_in = phase_ff;
      end

      if (end_of_text) begin
         case (mode_ff)
            MODE_NAME: begin
               e1_v = 1'b1;  e1_kind = KIND_NAME;
            end
            MODE_STR: begin
               e1_v = 1'b1;  e1_kind = KIND_STRING;
            end
            MODE_NUM: begin
               e1_v = 1'b1;  e1_kind = KIND_NUMBER;
            end
            default: begin
               e1_v = 1'b0;
            end
         endcase
         mode_in  = MODE_IDLE;
         phase_in = PHASE_INT;
         pos_in   = '0;
         start_in = '0;
      end else begin
         case (mode_ff)
            MODE_NAME: begin
               if (!(is_alpha(text_char) || is_digit(text_char))) begin
                  e1_v = 1'b1;  e1_kind = KIND_NAME;  relex = 1'b1;
               end
            end
            MODE_STR: begin
               if (text_char == CHAR_QUOTE) begin
                  e1_v = 1'b1;  e1_kind = KIND_STRING;  mode_in = MODE_IDLE;
               end
            end
            MODE_NUM: begin
               if (!takes) begin
                  e1_v = 1'b1;  e1_kind = KIND_NUMBER;
                  phase_in = PHASE_INT;  relex = 1'b1;
               end
            end
            MODE_SLASH: begin
               if (text_char == CHAR_SLASH) begin
                  mode_in = MODE_COMMENT;
               end else begin
                  relex = 1'b1;
               end
            end
            MODE_COMMENT: begin
               if (text_char == CHAR_NEWLINE) begin
                  mode_in = MODE_IDLE;
               end
            end
            default: begin
               relex = 1'b1;
            end
         endcase

         // terminating byte, or any byte in idle mode, lexed afresh at its own offset
         if (relex) begin
            mode_in = MODE_IDLE;
            if (is_digit(text_char)) begin
               mode_in = MODE_NUM;  phase_in = PHASE_INT;  start_in = pos_ff;
            end else if (is_alpha(text_char)) begin
               mode_in = MODE_NAME;  start_in = pos_ff;
            end else if (text_char == CHAR_QUOTE) begin
               mode_in = MODE_STR;  start_in = pos_ff + POS_W'(1);
            end else if (text_char == CHAR_SLASH) begin
               mode_in = MODE_SLASH;
            end else if (text_char == CHAR_LBRACE) begin
               e2_v = 1'b1;  e2_kind = KIND_LBRACE;
            end else if (text_char == CHAR_RBRACE) begin
               e2_v = 1'b1;  e2_kind = KIND_RBRACE;
            end else if (text_char == CHAR_COLON) begin
               e2_v = 1'b1;  e2_kind = KIND_COLON;
            end else if (text_char == CHAR_COMMA) begin
               e2_v = 1'b1;  e2_kind = KIND_COMMA;
            end
         end
      end

      // token limit
      k1        = e1_v && (count_ff < token_limit);
      count_mid = count_ff + LIMIT_W'(k1);
      k2        = e2_v && (count_mid < token_limit);
      count_in  = end_of_text ? '0 : count_mid + LIMIT_W'(k2);

      tok1 = '{last: 1'b0, kind: e1_kind, start: start_ff, length: span};
      tok2 = '{last: 1'b1, kind: e2_kind, start: pos_ff, length: '0};

      push = '0;
      if (k1) begin
         push.v0      = accept;
         push.t0      = tok1;
         push.t0.last = !k2;
         push.v1      = accept && k2;
         push.t1      = tok2;
      end else begin
         push.v0 = accept && k2;
         push.t0 = tok2;
         push.t1 = tok2;
      end
   end

endmodule

[rtl/cfglex_queue.sv]
// four-entry token queue taking up to two tokens per cycle, one out per cycle while out_ready is high
module cfglex_queue import cfglex_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   output logic     room,
   output logic     out_valid,
   input  logic     out_ready,
   output tok_type  out_tok
);

   tok_type     mem_ff [4];
   logic [1:0]  wr_ptr_ff, wr_ptr_in;
   logic [1:0]  rd_ptr_ff, rd_ptr_in;
   logic [2:0]  count_ff, count_in;
   logic        pop;
   logic [1:0]  push_n;

   always_comb begin
      out_valid = count_ff != 3'd0;
      room      = count_ff <= 3'd2;
      out_tok   = mem_ff[rd_ptr_ff];
      pop       = out_valid && out_ready;
      push_n    = {1'b0, push.v0} + {1'b0, push.v1};
      wr_ptr_in = wr_ptr_ff + push_n;
      rd_ptr_in = rd_ptr_ff + {1'b0, pop};
      count_in  = count_ff + {1'b0, push_n} - {2'b00, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.v0) begin
         mem_ff[wr_ptr_ff] <= push.t0;
      end
      if (push.v1) begin
         mem_ff[wr_ptr_ff + 2'd1] <= push.t1;
      end
   end

endmodule

[rtl/config_text_lexer.sv]
// top level of the streaming configuration text lexer
// The lexer takes one text byte per item on the req_ channel and returns
// tokens (open brace, close brace, colon, comma, name, quoted string,
// number) on the rsp_ channel, each with its start offset and span length;
// rsp_tlast marks the last token caused by one item. An item with req_tlast
// high carries no byte: it closes any pending name, number or string and
// starts a new text with offsets and token count back at zero. Whitespace,
// stray bytes, a lone slash and // comments are skipped; once token_limit
// tokens were sent in a text, further tokens are dropped. Rate: one item per
// clock cycle while the queue has room. Each item is lexed in the cycle it is
// accepted and its tokens (zero, one or two) go into a four-entry output queue
// that sends one token per cycle while rsp_tready is high, and input is held
// off while the queue has fewer than two free entries. The tokens of an
// accepted item are registered in the queue behind any tokens still waiting.
module config_text_lexer import cfglex_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   // input item channel
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [7:0]         req_tdata,    // [7:0] text_char
   input  logic               req_tlast,    // end_of_text
   // token channel
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [DATA_W-1:0]  rsp_tdata,    // [2:0] token_kind, [18:3] token_start,
                                            // [34:19] token_length, [39:35] zero
   output logic               rsp_tlast,    // run_last
   // token_limit register
   input  logic               csr_wr_en,
   input  logic [LIMIT_W-1:0] csr_wr_data
);

   logic [LIMIT_W-1:0] limit_ff;
   logic               accept;
   logic               room;
   push_type           push;
   tok_type            head;

   // token limit register, kept across texts
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_wr_en) begin
         limit_ff <= csr_wr_data;
      end
   end

   // take an item whenever the queue can absorb two tokens
   assign req_tready = room;
   assign accept     = req_tvalid && req_tready;

   cfglex_core u_core (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .text_char   (req_tdata),
      .end_of_text (req_tlast),
      .token_limit (limit_ff),
      .push        (push)
   );

   cfglex_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_tok   (head)
   );

   // pack the head token
   assign rsp_tdata = {5'b00000, head.length, head.start, head.kind};
   assign rsp_tlast = head.last;

endmodule
